@@ rtl/uv_sphere_index_generator_defines.svh @@
// Assertion macros for the sphere index generator RTL, used by the walker.
`ifndef UV_SPHERE_INDEX_GENERATOR_DEFINES_SVH
`define UV_SPHERE_INDEX_GENERATOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define UVS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define UVS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/uvs_pkg.sv @@
// Package with shared constants and types of the sphere index generator.
`default_nettype none
package uvs_pkg;

    localparam int DEFAULT_MAX_DIV = 256;

    localparam int CFG_DIV_W  = 9;
    localparam int IDX_W      = 16;
    localparam int CFG_DATA_W = 16;
    localparam int REG_IDX_W  = 2;

    localparam logic [REG_IDX_W-1:0] REG_LAT_DIV      = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_LONG_DIV     = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_VERTEX_COUNT = 2'd2;

    localparam logic [CFG_DIV_W-1:0] RST_LAT_DIV      = 9'd12;
    localparam logic [CFG_DIV_W-1:0] RST_LONG_DIV     = 9'd24;
    localparam logic [IDX_W-1:0]     RST_VERTEX_COUNT = 16'd266;

    // Values derived from the configuration for the cap triangles.
    typedef struct packed {
        logic [IDX_W-1:0] south_base;
        logic [IDX_W-1:0] pole_north;
        logic [IDX_W-1:0] pole_south;
    } geom_t;

    typedef struct packed {
        logic [IDX_W-1:0] idx_first;
        logic [IDX_W-1:0] idx_second;
        logic [IDX_W-1:0] idx_third;
        logic             last_triangle;
    } triangle_t;

endpackage
`default_nettype wire

@@ rtl/uvs_ifs.sv @@
// Channel interfaces: request, result and configuration write.
`default_nettype none
interface uvs_req_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink (input valid, input restart, output ready);
endinterface

interface uvs_res_if;
    logic                     valid;
    logic                     ready;
    logic [uvs_pkg::IDX_W-1:0] idx_first;
    logic [uvs_pkg::IDX_W-1:0] idx_second;
    logic [uvs_pkg::IDX_W-1:0] idx_third;
    logic                     last_triangle;

    modport source (output valid, output idx_first, output idx_second, output idx_third,
                    output last_triangle, input ready);
    modport sink (input valid, input idx_first, input idx_second, input idx_third,
                  input last_triangle, output ready);
endinterface

interface uvs_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [uvs_pkg::REG_IDX_W-1:0]  index;
    logic [uvs_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/uvs_cfg.sv @@
// Configuration registers with division clamping and cap geometry.
`default_nettype none
module uvs_cfg #(
    parameter int MAX_DIV = uvs_pkg::DEFAULT_MAX_DIV,
    parameter int DIV_W   = $clog2(MAX_DIV + 1)
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    uvs_cfg_if.sink            cfg,
    output logic [DIV_W-1:0]   lat,
    output logic [DIV_W-1:0]   lng,
    output uvs_pkg::geom_t     geom,
    output logic               cfg_wr
);
    import uvs_pkg::*;

    localparam int CMP_W = (DIV_W > CFG_DIV_W) ? DIV_W : CFG_DIV_W;
    localparam logic [CMP_W-1:0] MaxDivC = CMP_W'(MAX_DIV);
    localparam logic [CMP_W-1:0] MinDivC = CMP_W'(3);

    logic [CFG_DIV_W-1:0] lat_div_reg, lat_div_next;
    logic [CFG_DIV_W-1:0] long_div_reg, long_div_next;
    logic [IDX_W-1:0]     vertex_count_reg, vertex_count_next;
    logic [CMP_W-1:0]     lat_raw, lng_raw;
    logic [31:0]          south_prod;
    logic                 cfg_take;

    assign cfg.ready = 1'b1;
    assign cfg_take  = cfg.valid && cfg.ready;

    // Only a write that hits one of the registers returns the position to the start.
    always_comb
    begin
        lat_div_next      = lat_div_reg;
        long_div_next     = long_div_reg;
        vertex_count_next = vertex_count_reg;
        cfg_wr            = 1'b0;
        if (cfg_take)
        begin
            unique case (cfg.index)
                REG_LAT_DIV:
                begin
                    lat_div_next = cfg.data[CFG_DIV_W-1:0];
                    cfg_wr       = 1'b1;
                end
                REG_LONG_DIV:
                begin
                    long_div_next = cfg.data[CFG_DIV_W-1:0];
                    cfg_wr        = 1'b1;
                end
                REG_VERTEX_COUNT:
                begin
                    vertex_count_next = cfg.data[IDX_W-1:0];
                    cfg_wr            = 1'b1;
                end
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lat_div_reg      <= RST_LAT_DIV;
            long_div_reg     <= RST_LONG_DIV;
            vertex_count_reg <= RST_VERTEX_COUNT;
        end
        else
        begin
            lat_div_reg      <= lat_div_next;
            long_div_reg     <= long_div_next;
            vertex_count_reg <= vertex_count_next;
        end
    end

    assign lat_raw = CMP_W'(lat_div_reg);
    assign lng_raw = CMP_W'(long_div_reg);

    always_comb
    begin
        if (lat_raw < MinDivC)
            lat = DIV_W'(MinDivC);
        else if (lat_raw > MaxDivC)
            lat = DIV_W'(MaxDivC);
        else
            lat = DIV_W'(lat_raw);

        if (lng_raw < MinDivC)
            lng = DIV_W'(MinDivC);
        else if (lng_raw > MaxDivC)
            lng = DIV_W'(MaxDivC);
        else
            lng = DIV_W'(lng_raw);
    end

    // The southmost ring row is lat - 2; its first vertex is that row times lng.
    assign south_prod = 32'(lat - DIV_W'(2)) * 32'(lng);
    assign geom       = '{south_base: south_prod[IDX_W-1:0],
                          pole_north: vertex_count_reg - IDX_W'(2),
                          pole_south: vertex_count_reg - IDX_W'(1)};

endmodule
`default_nettype wire

@@ rtl/uvs_walker.sv @@
// Mesh position counters and triangle index computation.
`default_nettype none
`include "uv_sphere_index_generator_defines.svh"
module uvs_walker #(
    parameter int MAX_DIV = uvs_pkg::DEFAULT_MAX_DIV,
    parameter int DIV_W   = $clog2(MAX_DIV + 1),
    parameter int CNT_W   = $clog2(MAX_DIV)
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic [DIV_W-1:0] lat,
    input  wire logic [DIV_W-1:0] lng,
    input  wire uvs_pkg::geom_t geom,
    input  wire logic           cfg_wr,
    input  wire logic           accept,
    input  wire logic           restart,
    output uvs_pkg::triangle_t  triangle
);
    import uvs_pkg::*;

    logic [CNT_W-1:0] row_reg, row_next;
    logic [CNT_W-1:0] col_reg, col_next;
    logic             cap_reg, cap_next;
    logic             half_reg, half_next;
    logic [IDX_W-1:0] row_base_reg, row_base_next;

    logic [CNT_W-1:0] row_eff, col_eff;
    logic             cap_eff, half_eff;
    logic [IDX_W-1:0] rb_eff, nb, lng16, c16, c1_16;
    logic [DIV_W-1:0] col_inc, row_inc, lat_m2;
    logic             wrap, row_done;
    logic [31:0]      rb_check;

    // A restart request works on the first triangle as if the position were cleared.
    assign row_eff  = restart ? '0 : row_reg;
    assign col_eff  = restart ? '0 : col_reg;
    assign cap_eff  = restart ? 1'b0 : cap_reg;
    assign half_eff = restart ? 1'b0 : half_reg;
    assign rb_eff   = restart ? '0 : row_base_reg;

    assign col_inc  = DIV_W'(col_eff) + DIV_W'(1);
    assign wrap     = col_inc >= lng;
    assign row_inc  = DIV_W'(row_eff) + DIV_W'(1);
    assign lat_m2   = lat - DIV_W'(2);
    assign row_done = row_inc >= lat_m2;

    assign lng16 = IDX_W'(lng);
    assign c16   = IDX_W'(col_eff);
    assign c1_16 = wrap ? '0 : IDX_W'(col_inc);
    assign nb    = rb_eff + lng16;

    always_comb
    begin
        triangle.last_triangle = 1'b0;
        if (!cap_eff)
        begin
            if (!half_eff)
            begin
                triangle.idx_first  = rb_eff + c16;
                triangle.idx_second = nb + c16;
                triangle.idx_third  = rb_eff + c1_16;
            end
            else
            begin
                triangle.idx_first  = rb_eff + c1_16;
                triangle.idx_second = nb + c16;
                triangle.idx_third  = nb + c1_16;
            end
        end
        else
        begin
            if (!half_eff)
            begin
                triangle.idx_first  = geom.pole_north;
                triangle.idx_second = c16;
                triangle.idx_third  = c1_16;
            end
            else
            begin
                triangle.idx_first     = geom.south_base + c1_16;
                triangle.idx_second    = geom.south_base + c16;
                triangle.idx_third     = geom.pole_south;
                triangle.last_triangle = wrap;
            end
        end
    end

    always_comb
    begin
        row_next      = row_reg;
        col_next      = col_reg;
        cap_next      = cap_reg;
        half_next     = half_reg;
        row_base_next = row_base_reg;
        if (cfg_wr)
        begin
            row_next      = '0;
            col_next      = '0;
            cap_next      = 1'b0;
            half_next     = 1'b0;
            row_base_next = '0;
        end
        else if (accept)
        begin
            row_next      = row_eff;
            col_next      = col_eff;
            cap_next      = cap_eff;
            row_base_next = rb_eff;
            if (!half_eff)
            begin
                half_next = 1'b1;
            end
            else
            begin
                half_next = 1'b0;
                if (!wrap)
                begin
                    col_next = col_inc[CNT_W-1:0];
                end
                else
                begin
                    col_next = '0;
                    if (!cap_eff && !row_done)
                    begin
                        row_next      = row_inc[CNT_W-1:0];
                        row_base_next = nb;
                    end
                    else
                    begin
                        // End of the band moves to the caps; end of the caps starts over.
                        row_next      = '0;
                        row_base_next = '0;
                        cap_next      = !cap_eff;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg      <= '0;
            col_reg      <= '0;
            cap_reg      <= 1'b0;
            half_reg     <= 1'b0;
            row_base_reg <= '0;
        end
        else
        begin
            row_reg      <= row_next;
            col_reg      <= col_next;
            cap_reg      <= cap_next;
            half_reg     <= half_next;
            row_base_reg <= row_base_next;
        end
    end

    assign rb_check = 32'(row_reg) * 32'(lng);

    `UVS_ASSERT_NOW(a_col_in_range, clk, rst_n, 1'b1,
        (DIV_W'(col_reg) < lng), "column counter reached the longitude count")
    `UVS_ASSERT_NOW(a_cap_row_clear, clk, rst_n, cap_reg,
        (row_reg == '0 && row_base_reg == '0), "row state not cleared in the caps")
    `UVS_ASSERT_NOW(a_row_base_match, clk, rst_n, !cap_reg,
        (row_base_reg == rb_check[IDX_W-1:0]), "row base differs from row times lng")
    `UVS_ASSERT_NEXT(a_last_wraps, clk, rst_n, (accept && triangle.last_triangle),
        (row_reg == '0 && col_reg == '0 && !cap_reg && !half_reg),
        "position did not return to the first triangle")

endmodule
`default_nettype wire

@@ rtl/uvs_out_stage.sv @@
// Result register between the index logic and the result channel.
`default_nettype none
module uvs_out_stage (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          load,
    input  wire uvs_pkg::triangle_t triangle,
    output logic               can_load,
    uvs_res_if.source          res
);
    import uvs_pkg::*;

    logic      valid_reg, valid_next;
    triangle_t data_reg;

    assign can_load   = !valid_reg || res.ready;
    assign valid_next = load || (valid_reg && !res.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= triangle;
    end

    assign res.valid         = valid_reg;
    assign res.idx_first     = data_reg.idx_first;
    assign res.idx_second    = data_reg.idx_second;
    assign res.idx_third     = data_reg.idx_third;
    assign res.last_triangle = data_reg.last_triangle;

endmodule
`default_nettype wire

@@ rtl/uv_sphere_index_generator.sv @@
// Top level of the UV sphere triangle index generator.
// Each accepted request yields one triangle of the latitude/longitude sphere mesh: band rows
// first, two triangles per segment, then alternating north and south cap triangles, with
// last_triangle set on the final one, after which the sequence wraps. A request with restart
// set yields the first triangle again. One request is taken every clock cycle while
// request.ready is high; the result is held in a single output register and shows up in the
// cycle after acceptance, and request.ready stays high while that register is empty or being
// read in the same cycle. Configuration writes are always ready and take effect from the next
// cycle; a write to one of the three registers returns the position to the first triangle, a
// write to any other index does nothing.
`default_nettype none
module uv_sphere_index_generator #(
    parameter int MAX_DIV = uvs_pkg::DEFAULT_MAX_DIV
) (
    input  wire logic clk,
    input  wire logic rst_n,
    uvs_req_if.sink   request,
    uvs_res_if.source result,
    uvs_cfg_if.sink   cfg
);
    import uvs_pkg::*;

    localparam int DIV_W = $clog2(MAX_DIV + 1);
    localparam int CNT_W = $clog2(MAX_DIV);

    logic [DIV_W-1:0] lat, lng;
    geom_t            geom;
    triangle_t        triangle;
    logic             cfg_wr, can_load, accept;

    assign request.ready = can_load;
    assign accept        = request.valid && can_load;

    uvs_cfg #(
        .MAX_DIV (MAX_DIV),
        .DIV_W   (DIV_W)
    ) u_cfg (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .lat    (lat),
        .lng    (lng),
        .geom   (geom),
        .cfg_wr (cfg_wr)
    );

    uvs_walker #(
        .MAX_DIV (MAX_DIV),
        .DIV_W   (DIV_W),
        .CNT_W   (CNT_W)
    ) u_walker (
        .clk      (clk),
        .rst_n    (rst_n),
        .lat      (lat),
        .lng      (lng),
        .geom     (geom),
        .cfg_wr   (cfg_wr),
        .accept   (accept),
        .restart  (request.restart),
        .triangle (triangle)
    );

    uvs_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (accept),
        .triangle (triangle),
        .can_load (can_load),
        .res      (result)
    );

endmodule
`default_nettype wire

@@ tb/tb_uv_sphere_index_generator.sv @@
// Testbench for the UV sphere index generator: random triangle requests checked by a mesh predictor.
`timescale 1ns / 100ps

module tb_uv_sphere_index_generator;
    import uvs_pkg::*;

    localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int MESH_MAX_DIV = DEFAULT_MAX_DIV;
    localparam int HOLD_CYCLES = 80;
    localparam int CYCLE_LIMIT = 500000;
    localparam int TARGET_ITEMS = 1350;

    // Walks the sphere mesh in the same order as the block and keeps the triangles still owed.
    class triangle_scoreboard;
        logic [CFG_DIV_W-1:0] lat_reg;
        logic [CFG_DIV_W-1:0] long_reg;
        logic [IDX_W-1:0]     vcount_reg;
        int unsigned          row_cnt;
        int unsigned          col_cnt;
        int unsigned          row_base;
        bit                   in_caps;
        bit                   second_half;
        triangle_t            expected_q[$];
        int                   errors;

        function new();
            lat_reg = RST_LAT_DIV;
            long_reg = RST_LONG_DIV;
            vcount_reg = RST_VERTEX_COUNT;
            errors = 0;
            rewind();
        endfunction

        function void rewind();
            row_cnt = 0;
            col_cnt = 0;
            row_base = 0;
            in_caps = 1'b0;
            second_half = 1'b0;
        endfunction

        function int unsigned clamp_div(logic [CFG_DIV_W-1:0] v);
            if (v < 3)
                return 3;
            if (v > MESH_MAX_DIV)
                return MESH_MAX_DIV;
            return v;
        endfunction

        function void write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_LAT_DIV:      lat_reg = data[CFG_DIV_W-1:0];
                REG_LONG_DIV:     long_reg = data[CFG_DIV_W-1:0];
                REG_VERTEX_COUNT: vcount_reg = data[IDX_W-1:0];
                default:          return;
            endcase
            rewind();
        endfunction

        function void note_request(bit restart);
            int unsigned lat;
            int unsigned lng;
            int unsigned c;
            int unsigned c1;
            int unsigned a;
            int unsigned b;
            int unsigned t;
            int unsigned rb_next;
            int unsigned south_base;
            triangle_t   want;
            lat = clamp_div(lat_reg);
            lng = clamp_div(long_reg);
            if (restart)
                rewind();
            c = col_cnt;
            c1 = (c + 1 >= lng) ? 0 : c + 1;
            want.last_triangle = 1'b0;
            if (!in_caps)
            begin
                rb_next = row_base + lng;
                if (!second_half)
                begin
                    a = row_base + c;
                    b = rb_next + c;
                    t = row_base + c1;
                end
                else
                begin
                    a = row_base + c1;
                    b = rb_next + c;
                    t = rb_next + c1;
                end
            end
            else
            begin
                south_base = (lat - 2) * lng;
                if (!second_half)
                begin
                    a = 32'(vcount_reg) - 32'd2;
                    b = c;
                    t = c1;
                end
                else
                begin
                    a = south_base + c1;
                    b = south_base + c;
                    t = 32'(vcount_reg) - 32'd1;
                    want.last_triangle = (c + 1 >= lng);
                end
            end
            want.idx_first = a[IDX_W-1:0];
            want.idx_second = b[IDX_W-1:0];
            want.idx_third = t[IDX_W-1:0];
            expected_q.push_back(want);

            if (!second_half)
                second_half = 1'b1;
            else
            begin
                second_half = 1'b0;
                col_cnt = c + 1;
                if (col_cnt >= lng)
                begin
                    col_cnt = 0;
                    if (!in_caps)
                    begin
                        row_cnt++;
                        row_base += lng;
                        // The last band row hands over to the caps.
                        if (row_cnt >= lat - 2)
                        begin
                            row_cnt = 0;
                            row_base = 0;
                            in_caps = 1'b1;
                        end
                    end
                    else
                        rewind();
                end
            end
        endfunction

        function void check_result(triangle_t got);
            triangle_t want;
            if (expected_q.size() == 0)
            begin
                $error("triangle %0d %0d %0d with no request outstanding",
                       got.idx_first, got.idx_second, got.idx_third);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.idx_first !== want.idx_first)
            begin
                $error("idx_first: expected %0d, got %0d", want.idx_first, got.idx_first);
                errors++;
            end
            if (got.idx_second !== want.idx_second)
            begin
                $error("idx_second: expected %0d, got %0d", want.idx_second, got.idx_second);
                errors++;
            end
            if (got.idx_third !== want.idx_third)
            begin
                $error("idx_third: expected %0d, got %0d", want.idx_third, got.idx_third);
                errors++;
            end
            if (got.last_triangle !== want.last_triangle)
            begin
                $error("last_triangle: expected %0d, got %0d",
                       want.last_triangle, got.last_triangle);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    uvs_req_if req_if ();
    uvs_res_if res_if ();
    uvs_cfg_if cfg_if ();

    uv_sphere_index_generator uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (req_if),
        .result  (res_if),
        .cfg     (cfg_if)
    );

    triangle_scoreboard sb = new();

    bit          hold_off_req = 1'b0;
    bit          rx_no_stall = 1'b0;
    int unsigned total_items = 0;
    int unsigned cycle_count = 0;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Returns at the edge where the request is taken; valid stays high.
    task automatic send_request(input bit rs, input int unsigned gap);
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            req_if.restart <= 1'($urandom);
            repeat (gap) @(posedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.restart <= rs;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        total_items++;
    endtask

    task automatic program_reg(input logic [REG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data <= data;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
    endtask

    // One edge first, so the monitor has noted the last request before the count is read.
    task automatic drain_triangles();
        req_if.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    always @(posedge clk)
    begin : monitor
        triangle_t got;
        if (rst_n)
        begin
            if (res_if.valid && res_if.ready)
            begin
                got.idx_first = res_if.idx_first;
                got.idx_second = res_if.idx_second;
                got.idx_third = res_if.idx_third;
                got.last_triangle = res_if.last_triangle;
                sb.check_result(got);
            end
            if (cfg_if.valid && cfg_if.ready)
                sb.write_reg(cfg_if.index, cfg_if.data);
            if (req_if.valid && req_if.ready)
                sb.note_request(req_if.restart);
        end
    end

    initial
    begin : receiver
        int unsigned n;
        res_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                // Long stall so the output register fills and request.ready drops.
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
            end
            else if (!rx_no_stall)
            begin
                n = gap_len();
                if (n > 0)
                begin
                    res_if.ready <= 1'b0;
                    repeat (n) @(posedge clk);
                end
            end
            res_if.ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin : stimulus
        int unsigned n;
        int unsigned odds;
        int unsigned phase;
        bit          big;
        bit          quiet;
        req_if.valid <= 1'b0;
        req_if.restart <= 1'b0;
        cfg_if.valid <= 1'b0;
        cfg_if.index <= REG_LAT_DIV;
        cfg_if.data <= '0;
        rst_n <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset geometry, with a restart on the third request.
        send_request(1'b0, 0);
        send_request(1'b0, 1);
        send_request(1'b1, 0);
        drain_triangles();

        // Division counts below the minimum clamp to three; poles wrap past zero.
        program_reg(REG_LAT_DIV, 16'hfe00);
        program_reg(REG_LONG_DIV, 16'h0002);
        program_reg(REG_VERTEX_COUNT, 16'd1);
        cfg_if.valid <= 1'b0;
        for (int k = 0; k < 14; k++)
            send_request(k == 13, gap_len());
        drain_triangles();

        // Division counts above the maximum clamp to the maximum.
        program_reg(REG_LAT_DIV, 16'h01ff);
        program_reg(REG_LONG_DIV, 16'h0101);
        program_reg(REG_VERTEX_COUNT, 16'hffff);
        cfg_if.valid <= 1'b0;
        for (int k = 0; k < 4; k++)
            send_request(1'b0, 0);
        drain_triangles();

        // A write past the last register leaves the position alone.
        program_reg(REG_UNUSED, 16'($urandom));
        cfg_if.valid <= 1'b0;
        for (int k = 0; k < 4; k++)
            send_request(1'b0, gap_len());

        phase = 0;
        while (total_items < TARGET_ITEMS)
        begin
            drain_triangles();
            big = ($urandom_range(0, 5) == 0);
            quiet = (phase != 1) && ($urandom_range(0, 3) == 0);
            if (phase == 0 || $urandom_range(0, 3) != 0)
                program_reg(REG_LAT_DIV, {7'($urandom),
                            9'(big ? $urandom_range(200, 511) : $urandom_range(0, 9))});
            if (phase == 0 || $urandom_range(0, 3) != 0)
                program_reg(REG_LONG_DIV, {7'($urandom),
                            9'(big ? $urandom_range(200, 511) : $urandom_range(0, 10))});
            if (phase == 0 || $urandom_range(0, 3) != 0)
                program_reg(REG_VERTEX_COUNT, $urandom_range(0, 1) ?
                            16'($urandom) : 16'($urandom_range(8, 300)));
            if ($urandom_range(0, 4) == 0)
                program_reg(REG_UNUSED, 16'($urandom));
            cfg_if.valid <= 1'b0;

            rx_no_stall = quiet;
            hold_off_req = (phase == 1);
            n = big ? $urandom_range(15, 40) : $urandom_range(30, 180);
            odds = $urandom_range(0, 1) ? 0 : $urandom_range(20, 60);
            for (int k = 0; k < n; k++)
                send_request(odds != 0 && $urandom_range(1, odds) == 1,
                             (quiet || phase == 1) ? 0 : gap_len());
            phase++;
        end
        drain_triangles();
        repeat (5) @(posedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/uvs_pkg.sv
rtl/uvs_ifs.sv
rtl/uvs_cfg.sv
rtl/uvs_walker.sv
rtl/uvs_out_stage.sv
rtl/uv_sphere_index_generator.sv
tb/tb_uv_sphere_index_generator.sv
